@@ rtl/melody_sequencer_with_seek_top_defines.svh @@
// assertion macros for the melody sequencer
`ifndef MELODY_SEQUENCER_WITH_SEEK_TOP_DEFINES_SVH
`define MELODY_SEQUENCER_WITH_SEEK_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define MSS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define MSS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MSS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define MSS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

@@ rtl/mss_pkg.sv @@
package mss_pkg;

  localparam int MAX_NOTES_DEF = 256;

  // action codes of an input word
  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_TOGGLE    = 3'd1;
  localparam logic [2:0] ACT_RESET     = 3'd2;
  localparam logic [2:0] ACT_SEEK_FWD  = 3'd3;
  localparam logic [2:0] ACT_SEEK_BACK = 3'd4;
  localparam logic [2:0] ACT_LOAD      = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_SONG_LENGTH = 2'd0;
  localparam logic [1:0] REG_NOTE_GAP    = 2'd1;
  localparam logic [1:0] REG_SEEK_SPAN   = 2'd2;
  localparam logic [1:0] REG_REST_CODE   = 2'd3;

  localparam logic [15:0] SEEK_SPAN_RST = 16'd5000;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_t;

  // note store entry: frequency above, duration below
  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
  } note_t;

endpackage

@@ rtl/mss_ram.sv @@
module mss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/melody_sequencer_with_seek_top.sv @@
// a word goes from idle to emit, where the output register is loaded once it is free;
// a tick that starts a note passes a tick state first (one note store read); a seek that
// moves alternates check and add states per note entry walked; one word at a time
// the output register holds a result while the next word is being worked on
// reset: synchronous, clears player state to paused at position 0, led on,
// buzzer off, registers to defaults; the note store is not cleared
`include "melody_sequencer_with_seek_top_defines.svh"

module melody_sequencer_with_seek_top #(
  parameter int MAX_NOTES = mss_pkg::MAX_NOTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  load_index,
  input  logic [15:0] load_freq,
  input  logic [15:0] load_duration,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] tone_freq,
  output logic        tone_on,
  output logic        led,
  output logic [8:0]  position,
  output logic [1:0]  play_state,
  output logic        note_started
);

  import mss_pkg::*;

  localparam int AW = $clog2(MAX_NOTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_SEEK_CHK,
    S_SEEK_ADD,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [8:0]  song_length;
  logic [15:0] note_gap;
  logic [15:0] seek_span;
  logic [15:0] rest_code;

  // player state
  logic [8:0]  play_index;
  mode_t       player_mode;
  logic [16:0] wait_count;
  logic        indicator;
  logic [15:0] current_tone;
  logic        buzzer_active;
  logic        started;

  // seek walk
  logic [8:0]  walk_pos;
  logic [16:0] walked;
  logic        walk_fwd;

  logic        accept;
  logic [8:0]  len;
  logic [16:0] wait_dec;
  logic [8:0]  rd_idx;
  logic [15:0] rd_wide;
  logic [15:0] wr_wide;
  logic        wr_en;
  note_t       wr_note;
  note_t       rd_note;
  logic [16:0] dur_eff;
  logic        player_silent;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // a song longer than the store plays only the stored part
  assign len      = (32'(song_length) > MAX_NOTES) ? 9'(MAX_NOTES) : song_length;
  assign wait_dec = (wait_count != 17'd0) ? wait_count - 17'd1 : 17'd0;

  assign player_silent = !buzzer_active && (current_tone == 16'd0) && (wait_count == 17'd0);

  always_comb begin
    priority if (state == S_SEEK_CHK && !walk_fwd) begin
      rd_idx = walk_pos - 9'd1;
    end else if (state == S_SEEK_CHK) begin
      rd_idx = walk_pos;
    end else begin
      rd_idx = play_index;
    end
  end

  assign rd_wide      = {7'd0, rd_idx};
  assign wr_wide      = {8'd0, load_index};
  assign wr_en        = accept && (action == ACT_LOAD) && (32'(load_index) < MAX_NOTES);
  assign wr_note.freq = load_freq;
  assign wr_note.dur  = load_duration;

  mss_ram #(
    .WIDTH ($bits(note_t)),
    .DEPTH (MAX_NOTES)
  ) u_note_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_wide[AW-1:0]),
    .wr_data (wr_note),
    .rd_addr (rd_wide[AW-1:0]),
    .rd_data (rd_note)
  );

  // zero duration counts as one millisecond
  assign dur_eff = (rd_note.dur == 16'd0) ? 17'd1 : {1'b0, rd_note.dur};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      song_length   <= 9'd0;
      note_gap      <= 16'd0;
      seek_span     <= SEEK_SPAN_RST;
      rest_code     <= 16'd0;
      play_index    <= 9'd0;
      player_mode   <= MODE_PAUSED;
      wait_count    <= 17'd0;
      indicator     <= 1'b1;
      current_tone  <= 16'd0;
      buzzer_active <= 1'b0;
      started       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SONG_LENGTH: song_length <= cfg_data[8:0];
          REG_NOTE_GAP:    note_gap    <= cfg_data;
          REG_SEEK_SPAN:   seek_span   <= cfg_data;
          REG_REST_CODE:   rest_code   <= cfg_data;
          default: ;
        endcase
      end

      // a word is (re)offered while in emit, otherwise the register drains
      priority if (state == S_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            started <= 1'b0;
            unique case (action)
              ACT_TICK: begin
                if (player_mode == MODE_PLAYING && wait_dec == 17'd0 && play_index < len) begin
                  // note entry read is on its way
                  state <= S_TICK;
                end else begin
                  state <= S_EMIT;
                  if (player_mode == MODE_PLAYING) begin
                    wait_count <= wait_dec;
                    if (wait_dec == 17'd0) begin
                      player_mode   <= MODE_PAUSED;
                      current_tone  <= 16'd0;
                      buzzer_active <= 1'b0;
                      indicator     <= 1'b1;
                      play_index    <= 9'd0;
                    end
                  end
                end
              end
              ACT_TOGGLE: begin
                state      <= S_EMIT;
                wait_count <= 17'd0;
                if (player_mode == MODE_PLAYING) begin
                  player_mode   <= MODE_PAUSED;
                  current_tone  <= 16'd0;
                  buzzer_active <= 1'b0;
                  indicator     <= 1'b1;
                end else begin
                  player_mode <= MODE_PLAYING;
                  if (play_index >= len) begin
                    play_index <= 9'd0;
                  end
                end
              end
              ACT_RESET: begin
                state         <= S_EMIT;
                player_mode   <= MODE_PAUSED;
                current_tone  <= 16'd0;
                buzzer_active <= 1'b0;
                wait_count    <= 17'd0;
                indicator     <= 1'b1;
                play_index    <= 9'd0;
              end
              ACT_SEEK_FWD: begin
                if (play_index < len) begin
                  walk_pos <= play_index;
                  walked   <= 17'd0;
                  walk_fwd <= 1'b1;
                  state    <= S_SEEK_CHK;
                end else begin
                  state <= S_EMIT;
                end
              end
              ACT_SEEK_BACK: begin
                if (play_index != 9'd0) begin
                  walk_pos <= play_index;
                  walked   <= 17'd0;
                  walk_fwd <= 1'b0;
                  state    <= S_SEEK_CHK;
                end else begin
                  state <= S_EMIT;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end

        S_TICK: begin
          if (rd_note.freq == rest_code) begin
            current_tone  <= 16'd0;
            buzzer_active <= 1'b0;
          end else begin
            current_tone  <= rd_note.freq;
            buzzer_active <= 1'b1;
          end
          indicator  <= !indicator;
          wait_count <= dur_eff + {1'b0, note_gap};
          play_index <= play_index + 9'd1;
          started    <= 1'b1;
          state      <= S_EMIT;
        end

        S_SEEK_CHK: begin
          priority if (walked >= {1'b0, seek_span}) begin
            play_index <= walk_pos;
            wait_count <= 17'd0;
            state      <= S_EMIT;
          end else if (walk_fwd) begin
            // stop at the song end when no further note is left
            if ({1'b0, walk_pos} + 10'd1 >= {1'b0, len}) begin
              play_index <= len;
              wait_count <= 17'd0;
              state      <= S_EMIT;
            end else begin
              walk_pos <= walk_pos + 9'd1;
              state    <= S_SEEK_ADD;
            end
          end else begin
            if (walk_pos == 9'd0) begin
              play_index <= walk_pos;
              wait_count <= 17'd0;
              state      <= S_EMIT;
            end else begin
              walk_pos <= walk_pos - 9'd1;
              state    <= S_SEEK_ADD;
            end
          end
        end

        S_SEEK_ADD: begin
          walked <= walked + {1'b0, rd_note.dur};
          state  <= S_SEEK_CHK;
        end

        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            tone_freq    <= current_tone;
            tone_on      <= buzzer_active;
            led          <= indicator;
            position     <= play_index;
            play_state   <= player_mode;
            note_started <= started;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `MSS_ASSERT_NXT(a_accept_busy, clk, rst, accept, state != S_IDLE)
  `MSS_ASSERT_IMP(a_tick_after_accept, clk, rst, state == S_TICK, $past(accept))
  `MSS_ASSERT_IMP(a_paused_silent, clk, rst, player_mode == MODE_PAUSED, player_silent)
  `MSS_ASSERT_IMP(a_start_while_playing, clk, rst, out_valid && note_started, play_state == MODE_PLAYING)

endmodule

@@ dv/tb_melody_sequencer_with_seek_top.sv @@
module tb_melody_sequencer_with_seek_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int MAX_N = MAX_NOTES_DEF;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int DRAIN_CYCLES = 8;
  // longest seek walks the whole store
  localparam int TAIL_CYCLES = 600;
  localparam int HOLD_CYCLES = 150;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [7:0]  load_index;
  logic [15:0] load_freq;
  logic [15:0] load_duration;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] tone_freq;
  logic        tone_on;
  logic        led;
  logic [8:0]  position;
  logic [1:0]  play_state;
  logic        note_started;

  typedef struct packed {
    logic [15:0] freq;
    logic        on;
    logic        led;
    logic [8:0]  pos;
    logic [1:0]  st;
    logic        started;
  } tone_word_t;

  tone_word_t expected_tones[$];
  tone_word_t want;
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;

  // player state as the block should hold it
  logic [15:0] note_freq_m [MAX_N];
  logic [15:0] note_dur_m [MAX_N];
  logic [8:0]  pos_m = '0;
  mode_t       mode_m = MODE_PAUSED;
  int unsigned wait_m = 0;
  logic        led_m = 1'b1;
  logic [15:0] tone_m = '0;
  logic        buzz_m = 1'b0;
  logic [8:0]  song_len_r = '0;
  logic [15:0] gap_r = '0;
  logic [15:0] span_r = SEEK_SPAN_RST;
  logic [15:0] rest_r = '0;

  melody_sequencer_with_seek_top u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .load_index(load_index),
    .load_freq(load_freq),
    .load_duration(load_duration),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tone_freq(tone_freq),
    .tone_on(tone_on),
    .led(led),
    .position(position),
    .play_state(play_state),
    .note_started(note_started)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("melody_sequencer_with_seek_top: mismatch");
    $finish;
  end

  function automatic int unsigned song_notes();
    return (song_len_r > MAX_N) ? MAX_N : int'(song_len_r);
  endfunction

  function automatic void halt_player();
    mode_m = MODE_PAUSED;
    tone_m = '0;
    buzz_m = 1'b0;
    wait_m = 0;
    led_m = 1'b1;
  endfunction

  function automatic void seek_walk(input bit fwd);
    int unsigned n;
    int unsigned walked;
    int unsigned p;
    n = song_notes();
    walked = 0;
    p = pos_m;
    if (fwd) begin
      if (p >= n) return;
      while (walked < span_r) begin
        if (p + 1 >= n) begin
          p = n;
          break;
        end
        walked += note_dur_m[p];
        p++;
      end
    end else begin
      if (p == 0) return;
      while (walked < span_r) begin
        if (p == 0) break;
        p--;
        walked += note_dur_m[p];
      end
    end
    pos_m = 9'(p);
    wait_m = 0;
  endfunction

  function automatic bit tick_note();
    int unsigned dur;
    if (mode_m != MODE_PLAYING) return 1'b0;
    if (wait_m > 0) wait_m--;
    if (wait_m != 0) return 1'b0;
    if (pos_m >= song_notes()) begin
      // end of song: pause back at the first note
      halt_player();
      pos_m = '0;
      return 1'b0;
    end
    dur = note_dur_m[pos_m];
    if (dur < 1) dur = 1;
    if (note_freq_m[pos_m] == rest_r) begin
      tone_m = '0;
      buzz_m = 1'b0;
    end else begin
      tone_m = note_freq_m[pos_m];
      buzz_m = 1'b1;
    end
    led_m = ~led_m;
    wait_m = dur + gap_r;
    pos_m = pos_m + 9'd1;
    return 1'b1;
  endfunction

  function automatic void predict_word(input logic [2:0] act, input logic [7:0] idx,
                                       input logic [15:0] f, input logic [15:0] d);
    tone_word_t w;
    bit started;
    started = 1'b0;
    case (act)
      ACT_TICK: started = tick_note();
      ACT_TOGGLE: begin
        if (mode_m == MODE_PLAYING) begin
          halt_player();
        end else begin
          mode_m = MODE_PLAYING;
          if (pos_m >= song_notes()) pos_m = '0;
          wait_m = 0;
        end
      end
      ACT_RESET: begin
        halt_player();
        pos_m = '0;
      end
      ACT_SEEK_FWD: seek_walk(1'b1);
      ACT_SEEK_BACK: seek_walk(1'b0);
      ACT_LOAD: begin
        note_freq_m[idx] = f;
        note_dur_m[idx] = d;
      end
      default: ;
    endcase
    w.freq = tone_m;
    w.on = buzz_m;
    w.led = led_m;
    w.pos = pos_m;
    w.st = mode_m;
    w.started = started;
    expected_tones.push_back(w);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t %s: expected %0h actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_tones.size() == 0) begin
        $display("%0t result word with nothing pending: expected none actual pos %0h",
                 $time, position);
        errors++;
      end else begin
        want = expected_tones.pop_front();
        check_field("tone_freq", want.freq, tone_freq);
        check_field("tone_on", 16'(want.on), 16'(tone_on));
        check_field("led", 16'(want.led), 16'(led));
        check_field("position", 16'(want.pos), 16'(position));
        check_field("play_state", 16'(want.st), 16'(play_state));
        check_field("note_started", 16'(want.started), 16'(note_started));
      end
    end
  end

  // result side: random stall, plus a long hold-off whenever hold_seq moves
  initial begin : receiver
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_word(input logic [2:0] act, input logic [7:0] idx,
                           input logic [15:0] f, input logic [15:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    load_index <= idx;
    load_freq <= f;
    load_duration <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(act, idx, f, d);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_tones.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [8:0] len, input logic [15:0] gap,
                              input logic [15:0] span, input logic [15:0] rest);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_SONG_LENGTH;
    cfg_data <= {7'd0, len};
    @(posedge clk);
    cfg_index <= REG_NOTE_GAP;
    cfg_data <= gap;
    @(posedge clk);
    cfg_index <= REG_SEEK_SPAN;
    cfg_data <= span;
    @(posedge clk);
    cfg_index <= REG_REST_CODE;
    cfg_data <= rest;
    @(posedge clk);
    cfg_write <= 1'b0;
    song_len_r = len;
    gap_r = gap;
    span_r = span;
    rest_r = rest;
  endtask

  function automatic logic [15:0] rand_freq();
    return ($urandom_range(3) == 0) ? 16'd440 : 16'($urandom);
  endfunction

  // mostly short notes so songs actually advance, now and then a long one
  function automatic logic [15:0] rand_dur();
    return ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(6));
  endfunction

  function automatic logic [2:0] pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return ACT_TICK;
    if (r < 63) return ACT_TOGGLE;
    if (r < 66) return ACT_RESET;
    if (r < 74) return ACT_SEEK_FWD;
    if (r < 82) return ACT_SEEK_BACK;
    if (r < 96) return ACT_LOAD;
    return ($urandom_range(1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7;
  endfunction

  task automatic random_words(input int n);
    repeat (n) send_word(pick_action(), 8'($urandom), rand_freq(), rand_dur());
  endtask

  task automatic test_directed();
    program_regs(9'd0, 16'd0, SEEK_SPAN_RST, 16'd0);
    // empty song: nothing to play, seeks at both ends, spare actions
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TOGGLE, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_FWD, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_BACK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SPARE_6, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_SPARE_7, 8'h00, 16'h0000, 16'h0000);
    send_word(ACT_RESET, 8'd0, 16'd0, 16'd0);
    // every store entry gets written before any song can reach it
    for (int i = 0; i < MAX_N; i++) send_word(ACT_LOAD, 8'(i), rand_freq(), rand_dur());
    send_word(ACT_LOAD, 8'd0, 16'hFFFF, 16'h0000);
    send_word(ACT_LOAD, 8'd1, 16'h0000, 16'h0002);
    send_word(ACT_LOAD, 8'd2, 16'h1234, 16'hFFFF);
    send_word(ACT_LOAD, 8'd3, 16'h0005, 16'h0001);
    program_regs(9'd4, 16'd0, 16'd1, 16'd0);
    send_word(ACT_TOGGLE, 8'd0, 16'd0, 16'd0);
    repeat (4) send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_FWD, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TOGGLE, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_BACK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_FWD, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_BACK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TOGGLE, 8'd0, 16'd0, 16'd0);
    send_word(ACT_RESET, 8'd0, 16'd0, 16'd0);
  endtask

  task automatic test_edge_config();
    // oversized song, widest gap, zero seek span, rest at all ones
    program_regs(9'h1FF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_word(ACT_TOGGLE, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_FWD, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_SEEK_BACK, 8'd0, 16'd0, 16'd0);
    program_regs(9'd256, 16'd0, 16'hFFFF, 16'd440);
    repeat (3) send_word(ACT_SEEK_FWD, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
    repeat (3) send_word(ACT_SEEK_BACK, 8'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 8'd0, 16'd0, 16'd0);
  endtask

  task automatic test_random_mix();
    idle_pct = 0;
    stall_pct = 0;
    program_regs(9'd16, 16'd0, SEEK_SPAN_RST, 16'd440);
    random_words(150);
    idle_pct = 47;
    program_regs(9'd256, 16'd2, 16'd20, 16'd0);
    random_words(150);
    idle_pct = 0;
    stall_pct = 47;
    program_regs(9'd1, 16'hFFFF, 16'd3, 16'd440);
    random_words(100);
    idle_pct = 32;
    stall_pct = 32;
    program_regs(9'd40, 16'd1, 16'd1, 16'hFFFF);
    random_words(150);
    program_regs(9'd9, 16'd3, 16'd0, 16'd0);
    random_words(85);
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    program_regs(9'd8, 16'd0, SEEK_SPAN_RST, 16'd440);
    // receiver holds off while words keep coming, so the input backs up
    hold_seq++;
    random_words(30);
    // sender waits for every result before going on
    drain_results();
    idle_pct = 32;
    stall_pct = 32;
    random_words(40);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_SONG_LENGTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= ACT_TICK;
    load_index <= '0;
    load_freq <= '0;
    load_duration <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_edge_config();
    test_random_mix();
    test_backpressure();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_tones.size() != 0) errors++;
    if (errors == 0) begin
      $display("melody_sequencer_with_seek_top: match");
    end else begin
      $display("melody_sequencer_with_seek_top: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_ram.sv
rtl/melody_sequencer_with_seek_top.sv
dv/tb_melody_sequencer_with_seek_top.sv
